### sv/command_tag_pool_defines.svh
// Assertion macros used by the checker file of the command tag pool.
`ifndef COMMAND_TAG_POOL_DEFINES_SVH
`define COMMAND_TAG_POOL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CTP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CTP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/ctp_pkg.sv
// Types, codes and constants shared by the command tag pool modules.
package ctp_pkg;

  localparam int NUM_TAGS_DEF = 64;
  localparam int CMD_W        = 3;
  localparam int TAG_W        = 6;
  localparam int MASK_W       = 64;
  localparam int KIND_W       = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_BUSY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_BUSY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POLL       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

  localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRANT,
    ST_GRANT_BUSY,
    ST_FREE,
    ST_REPORT
  } ctp_state_t;

  typedef struct packed {
    logic mark_busy;
    logic poll_start;
    logic grant_emit;
    logic grant_busy;
    logic free_emit;
    logic report_emit;
  } ctp_ctl_t;

  typedef struct packed {
    logic out_free;
    logic poll_any;
    logic scan_last;
  } ctp_sts_t;

endpackage

### sv/ctp_in_if.sv
// Request channel of the command tag pool.
interface ctp_in_if;
  import ctp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TAG_W-1:0]  tag;
  logic [MASK_W-1:0] busy_snapshot;

  modport source (output valid, cmd, tag, busy_snapshot, input ready);
  modport sink (input valid, cmd, tag, busy_snapshot, output ready);
endinterface

### sv/ctp_out_if.sv
// Result channel of the command tag pool.
interface ctp_out_if;
  import ctp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TAG_W-1:0]  tag_out;
  logic              pool_empty;
  logic [MASK_W-1:0] busy_mask;
  logic              last;

  modport source (output valid, kind, tag_out, pool_empty, busy_mask, last, input ready);
  modport sink (input valid, kind, tag_out, pool_empty, busy_mask, last, output ready);
endinterface

### sv/ctp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ctp_ctrl.sv
// Controller state machine of the command tag pool.
module ctp_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ctp_pkg::CMD_W-1:0] in_cmd,
  input  ctp_pkg::ctp_sts_t         sts,
  output logic                      in_ready,
  output ctp_pkg::ctp_ctl_t         ctl
);
  import ctp_pkg::*;

  ctp_state_t state_r;
  ctp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_ALLOC:      state_nxt = ST_GRANT;
            CMD_ALLOC_BUSY: state_nxt = ST_GRANT_BUSY;
            CMD_POLL:       state_nxt = sts.poll_any ? ST_FREE : ST_IDLE;
            CMD_READ:       state_nxt = ST_REPORT;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_GRANT, ST_GRANT_BUSY, ST_REPORT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FREE: begin
        if (sts.out_free && sts.scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    ctl.mark_busy   = (state_r == ST_IDLE) && in_valid && (in_cmd == CMD_MARK_BUSY);
    ctl.poll_start  = (state_r == ST_IDLE) && in_valid && (in_cmd == CMD_POLL);
    ctl.grant_emit  = ((state_r == ST_GRANT) || (state_r == ST_GRANT_BUSY)) && sts.out_free;
    ctl.grant_busy  = (state_r == ST_GRANT_BUSY);
    ctl.free_emit   = (state_r == ST_FREE) && sts.out_free;
    ctl.report_emit = (state_r == ST_REPORT) && sts.out_free;
  end

endmodule

### sv/ctp_dp.sv
// Datapath of the command tag pool: free ring, pointers, masks and result register.
module ctp_dp #(
  parameter int NUM_TAGS = ctp_pkg::NUM_TAGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctp_pkg::ctp_ctl_t          ctl,
  output ctp_pkg::ctp_sts_t          sts,
  input  logic [ctp_pkg::TAG_W-1:0]  in_tag,
  input  logic [ctp_pkg::MASK_W-1:0] in_snapshot,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [ctp_pkg::KIND_W-1:0] out_kind,
  output logic [ctp_pkg::TAG_W-1:0]  out_tag_out,
  output logic                       out_pool_empty,
  output logic [ctp_pkg::MASK_W-1:0] out_busy_mask,
  output logic                       out_last
);
  import ctp_pkg::*;

  localparam int IDX_W = $clog2(NUM_TAGS);
  localparam int CNT_W = $clog2(NUM_TAGS + 1);
  localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(NUM_TAGS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_TAGS);

  function automatic logic [IDX_W-1:0] encode_onehot(input logic [NUM_TAGS-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  logic [IDX_W-1:0]    pop_ptr_r, pop_ptr_nxt;
  logic [IDX_W-1:0]    push_ptr_r, push_ptr_nxt;
  logic                push_wrap_r, push_wrap_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [NUM_TAGS-1:0] busy_r, busy_nxt;
  logic [NUM_TAGS-1:0] pending_r, pending_nxt;
  logic [NUM_TAGS-1:0] scan_r, scan_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  logic                out_last_r, out_last_nxt;

  logic [IDX_W-1:0]    ring_rd_data;
  logic                ring_wr_en;
  logic                entry_written;
  logic [IDX_W-1:0]    grant_tag;
  logic [NUM_TAGS-1:0] snap_m;
  logic [NUM_TAGS-1:0] pend_or_busy;
  logic [NUM_TAGS-1:0] scan_low;
  logic [IDX_W-1:0]    free_tag;
  logic                out_free;

  ctp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_TAGS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (push_ptr_r),
    .wr_data (free_tag),
    .rd_addr (pop_ptr_r),
    .rd_data (ring_rd_data)
  );

  // Ring entries are pushed in address order from reset, so an entry never
  // written stands for its own index, which is used in place of the RAM data.
  assign entry_written = push_wrap_r || (pop_ptr_r < push_ptr_r);
  assign grant_tag     = entry_written ? ring_rd_data : pop_ptr_r;

  assign snap_m       = in_snapshot[NUM_TAGS-1:0];
  assign pend_or_busy = pending_r | busy_r;
  assign scan_low     = scan_r & (~scan_r + NUM_TAGS'(1));
  assign free_tag     = encode_onehot(scan_low);
  assign out_free     = !out_valid_r || out_ready;
  assign ring_wr_en   = ctl.free_emit && (count_r < CNT_FULL);

  assign sts.out_free  = out_free;
  assign sts.poll_any  = |(pend_or_busy & ~snap_m);
  assign sts.scan_last = ((scan_r & ~scan_low) == '0);

  always_comb begin
    pop_ptr_nxt   = pop_ptr_r;
    push_ptr_nxt  = push_ptr_r;
    push_wrap_nxt = push_wrap_r;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    pending_nxt   = pending_r;
    scan_nxt      = scan_r;

    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_empty_nxt = out_empty_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;

    if (ctl.mark_busy) begin
      busy_nxt = busy_r | (NUM_TAGS'(1) << in_tag);
    end

    if (ctl.poll_start) begin
      pending_nxt = pend_or_busy & snap_m;
      busy_nxt    = snap_m;
      scan_nxt    = pend_or_busy & ~snap_m;
    end

    if (ctl.grant_emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_GRANT;
      out_last_nxt  = 1'b1;
      if (count_r == '0) begin
        out_tag_nxt   = '0;
        out_empty_nxt = 1'b1;
      end else begin
        pop_ptr_nxt   = (pop_ptr_r == PTR_LAST) ? '0 : pop_ptr_r + IDX_W'(1);
        count_nxt     = count_r - CNT_W'(1);
        out_tag_nxt   = TAG_W'(grant_tag);
        out_empty_nxt = 1'b0;
        if (ctl.grant_busy) begin
          busy_nxt = busy_r | (NUM_TAGS'(1) << grant_tag);
        end
      end
      out_mask_nxt = MASK_W'(busy_nxt);
    end

    if (ctl.free_emit) begin
      scan_nxt      = scan_r & ~scan_low;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_FREED;
      out_tag_nxt   = TAG_W'(free_tag);
      out_empty_nxt = 1'b0;
      out_mask_nxt  = MASK_W'(busy_r);
      out_last_nxt  = sts.scan_last;
      if (ring_wr_en) begin
        push_ptr_nxt = (push_ptr_r == PTR_LAST) ? '0 : push_ptr_r + IDX_W'(1);
        if (push_ptr_r == PTR_LAST) begin
          push_wrap_nxt = 1'b1;
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (ctl.report_emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_REPORT;
      out_tag_nxt   = '0;
      out_empty_nxt = 1'b0;
      out_mask_nxt  = MASK_W'(busy_r);
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_ptr_r   <= '0;
      push_ptr_r  <= '0;
      push_wrap_r <= 1'b0;
      count_r     <= CNT_FULL;
      busy_r      <= '0;
      pending_r   <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pop_ptr_r   <= pop_ptr_nxt;
      push_ptr_r  <= push_ptr_nxt;
      push_wrap_r <= push_wrap_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      pending_r   <= pending_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_empty_r <= out_empty_nxt;
    out_mask_r  <= out_mask_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_tag_out    = out_tag_r;
  assign out_pool_empty = out_empty_r;
  assign out_busy_mask  = out_mask_r;
  assign out_last       = out_last_r;

endmodule

### sv/command_tag_pool.sv
// Command tag pool: top level joining the controller and the datapath.
//
// Requests arrive on in_req with a command, a tag and a hardware busy
// snapshot. Results leave on out_rsp, each with a kind, a tag, an empty flag,
// the busy mask and a last flag on the final result of its request.
// Allocate, allocate-and-issue and read each give one result, registered
// from the grant or report state that follows the request. Mark-busy gives
// no result. A poll releases its freed tags in ascending order; a poll
// that frees nothing gives no result. The grant tag comes from the
// registered read of the free-ring memory at the pop pointer, and a poll
// releases one freed tag per cycle while out_rsp takes its results.
// Requests are taken one at a time: in_req.ready is high only between requests.
// When out_rsp stalls, the waiting result holds in the output register and
// no new result is formed until it is taken.
// After reset the ring holds every tag in order, all tags are free, and the
// busy and pending masks are clear; the block is ready at once.
module command_tag_pool #(
  parameter int NUM_TAGS = ctp_pkg::NUM_TAGS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  ctp_in_if.sink        in_req,
  ctp_out_if.source     out_rsp
);
  import ctp_pkg::*;

  ctp_ctl_t ctl;
  ctp_sts_t sts;
  logic     ctrl_ready;

  ctp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_cmd   (in_req.cmd),
    .sts      (sts),
    .in_ready (ctrl_ready),
    .ctl      (ctl)
  );

  ctp_dp #(
    .NUM_TAGS (NUM_TAGS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_tag         (in_req.tag),
    .in_snapshot    (in_req.busy_snapshot),
    .out_ready      (out_rsp.ready),
    .out_valid      (out_rsp.valid),
    .out_kind       (out_rsp.kind),
    .out_tag_out    (out_rsp.tag_out),
    .out_pool_empty (out_rsp.pool_empty),
    .out_busy_mask  (out_rsp.busy_mask),
    .out_last       (out_rsp.last)
  );

  assign in_req.ready = ctrl_ready;

endmodule

### sv/ctp_checker.sv
// Port-level assertion checker for the command tag pool and its bind.
`include "command_tag_pool_defines.svh"

module ctp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [ctp_pkg::CMD_W-1:0]  in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ctp_pkg::KIND_W-1:0] out_kind,
  input logic [ctp_pkg::TAG_W-1:0]  out_tag_out,
  input logic                       out_pool_empty,
  input logic [ctp_pkg::MASK_W-1:0] out_busy_mask,
  input logic                       out_last
);
  import ctp_pkg::*;

  `CTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_tag_out) && $stable(out_busy_mask)
    && $stable(out_last) && $stable(out_pool_empty),
    "Stalled result changed before it was taken.")

  `CTP_ASSERT_NOW(a_single_last, out_valid && (out_kind == KIND_GRANT || out_kind == KIND_REPORT),
    out_last, "Grant or report result without the last flag.")

  `CTP_ASSERT_NOW(a_empty_grant, out_valid && out_pool_empty,
    out_kind == KIND_GRANT && out_tag_out == '0,
    "Empty-pool flag on a result that is not a failed grant.")

  `CTP_ASSERT_NEXT(a_read_busy, in_valid && in_ready && in_cmd == CMD_READ,
    !in_ready, "New request taken while a read result was still being formed.")

endmodule

bind command_tag_pool ctp_checker u_ctp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .in_cmd         (in_req.cmd),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_kind       (out_rsp.kind),
  .out_tag_out    (out_rsp.tag_out),
  .out_pool_empty (out_rsp.pool_empty),
  .out_busy_mask  (out_rsp.busy_mask),
  .out_last       (out_rsp.last)
);
